// ----- rtl/rssb_pkg.sv -----
// Package for the retained sample slot bank.
// Holds the operation codes, controller states and the command struct that the
// controller sends to the slot cells. It depends on nothing else.
package rssb_pkg;

    localparam int IDX_W  = 6;
    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        MODE_STORE_FREE = 2'd0,
        MODE_STORE_AT   = 2'd1,
        MODE_READ       = 2'd2,
        MODE_CLEAR      = 2'd3
    } t_mode;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Command that is broadcast to every cell during the execute cycle.
    typedef struct packed {
        logic              wr_free;
        logic              wr_at;
        logic              clear;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] time_word;
        logic [WORD_W-1:0] value_word;
    } t_cell_cmd;

endpackage

// ----- rtl/rssb_cell.sv -----
// One slot cell of the retained sample slot bank.
// Depends on rssb_pkg for the command struct; cells are chained through the
// free-slot claim signal, which each cell passes on to its upper neighbour.
module rssb_cell
    import rssb_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_cmd         i_cmd,
    input  logic              i_claim,
    output logic              o_claim,
    output logic              o_grant,
    output logic              o_rd_hit,
    output logic [WORD_W-1:0] o_rd_time,
    output logic [WORD_W-1:0] o_rd_value
);

    logic              r_used;
    logic [WORD_W-1:0] r_time;
    logic [WORD_W-1:0] r_value;
    logic              hit;
    logic              wr;

    // A lower cell that is free has already claimed the store.
    assign o_grant = !r_used && !i_claim;
    assign o_claim = i_claim || !r_used;

    assign hit = (i_cmd.idx == IDX_W'(CELL_IDX));
    assign wr  = (i_cmd.wr_free && o_grant) || (i_cmd.wr_at && hit);

    assign o_rd_hit   = hit && r_used;
    assign o_rd_time  = o_rd_hit ? r_time  : '0;
    assign o_rd_value = o_rd_hit ? r_value : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_cmd.clear) begin
            r_used <= 1'b0;
        end else if (wr) begin
            r_used <= (i_cmd.time_word != '0) || (i_cmd.value_word != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_time  <= i_cmd.time_word;
            r_value <= i_cmd.value_word;
        end
    end

endmodule

// ----- rtl/retained_sample_slot_bank_top.sv -----
// Top level of the retained sample slot bank.
// Depends on rssb_pkg and instantiates one rssb_cell per slot.
//
// Usage. A command is transferred at a rising edge where start is high and busy
// is low; it carries a mode (store first free, store at index, read, clear), a
// slot index and a sample of one time word and one value word. Each command
// yields exactly one result, shown on the o_ result ports for one cycle and
// marked by o_valid; the receiver takes it at the edge that ends that cycle and
// cannot hold it off.
//
// Timing. The cycle after the transfer is the execute cycle, in which the row
// of cells is examined and written. The result appears in the cycle after that,
// and in that same cycle busy is already low, so a new command may be
// transferred while that result is shown. The timing follows from the
// registered command and the registered result around the cell row.
//
// Finding the lowest empty slot is done by a claim signal that ripples along
// the row of cells, each cell passing it to its upper neighbour. Reads select
// one cell by index and gather its words through an OR of all cells.
//
// Reset is synchronous and active low. It marks every slot empty and the bank
// invalid; the first store of either kind makes the bank valid. Slot words are
// not cleared, since an empty slot is never read out.
module retained_sample_slot_bank_top
    import rssb_pkg::*;
#(
    parameter int BANK_SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_mode,
    input  logic [IDX_W-1:0]  i_slot_index,
    input  logic [WORD_W-1:0] i_sample_time,
    input  logic [WORD_W-1:0] i_sample_value,
    output logic              o_valid,
    output logic              o_status,
    output logic [IDX_W-1:0]  o_stored_index,
    output logic [WORD_W-1:0] o_read_time,
    output logic [WORD_W-1:0] o_read_value
);

    t_state r_state;
    t_state n_state;

    // Command registers, loaded on a transfer.
    t_mode             r_mode;
    logic [IDX_W-1:0]  r_idx;
    logic [WORD_W-1:0] r_time;
    logic [WORD_W-1:0] r_value;

    logic r_bank_valid;
    logic n_bank_valid;

    // Result registers.
    logic              r_valid;
    logic              r_status;
    logic [IDX_W-1:0]  r_sidx;
    logic [WORD_W-1:0] r_rt;
    logic [WORD_W-1:0] r_rv;
    logic              n_status;
    logic [IDX_W-1:0]  n_sidx;
    logic [WORD_W-1:0] n_rt;
    logic [WORD_W-1:0] n_rv;

    logic      accept;
    logic      exec;
    t_cell_cmd cell_cmd;

    logic [BANK_SLOTS:0]   claim;
    logic [BANK_SLOTS-1:0] grant;
    logic [BANK_SLOTS-1:0] rd_hit;
    logic [WORD_W-1:0]     rd_time  [BANK_SLOTS];
    logic [WORD_W-1:0]     rd_value [BANK_SLOTS];

    logic              any_free;
    logic              any_hit;
    logic [IDX_W-1:0]  free_idx;
    logic [WORD_W-1:0] sel_time;
    logic [WORD_W-1:0] sel_value;

    // Controller: next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Controller: outputs.
    always_comb begin
        busy = 1'b0;
        exec = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                exec = 1'b0;
            end
            ST_EXEC: begin
                busy = 1'b1;
                exec = 1'b1;
            end
            default: begin
                busy = 1'b0;
                exec = 1'b0;
            end
        endcase
    end

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_bank_valid <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_bank_valid <= n_bank_valid;
            r_valid      <= exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= t_mode'(i_mode);
            r_idx   <= i_slot_index;
            r_time  <= i_sample_time;
            r_value <= i_sample_value;
        end
        if (exec) begin
            r_status <= n_status;
            r_sidx   <= n_sidx;
            r_rt     <= n_rt;
            r_rv     <= n_rv;
        end
    end

    // The command reaches the cells only during the execute cycle.
    always_comb begin
        cell_cmd.wr_free    = exec && (r_mode == MODE_STORE_FREE);
        cell_cmd.wr_at      = exec && (r_mode == MODE_STORE_AT);
        cell_cmd.clear      = exec && (r_mode == MODE_CLEAR);
        cell_cmd.idx        = r_idx;
        cell_cmd.time_word  = r_time;
        cell_cmd.value_word = r_value;
    end

    assign claim[0] = 1'b0;

    for (genvar k = 0; k < BANK_SLOTS; k++) begin : g_cell
        rssb_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cell_cmd),
            .i_claim    (claim[k]),
            .o_claim    (claim[k+1]),
            .o_grant    (grant[k]),
            .o_rd_hit   (rd_hit[k]),
            .o_rd_time  (rd_time[k]),
            .o_rd_value (rd_value[k])
        );
    end

    // At most one cell grants and at most one cell hits, so an OR gathers them.
    always_comb begin
        free_idx  = '0;
        sel_time  = '0;
        sel_value = '0;
        for (int k = 0; k < BANK_SLOTS; k++) begin
            free_idx  = free_idx | (grant[k] ? IDX_W'(k) : '0);
            sel_time  = sel_time | rd_time[k];
            sel_value = sel_value | rd_value[k];
        end
    end

    assign any_free = claim[BANK_SLOTS];
    assign any_hit  = |rd_hit;

    // Result of the command now in the execute cycle.
    always_comb begin
        n_status     = 1'b0;
        n_sidx       = '0;
        n_rt         = '0;
        n_rv         = '0;
        n_bank_valid = r_bank_valid;
        case (r_mode)
            MODE_STORE_FREE: begin
                n_status = !any_free;
                n_sidx   = any_free ? free_idx : '0;
                if (exec) begin
                    n_bank_valid = 1'b1;
                end
            end
            MODE_STORE_AT: begin
                n_status = (r_idx >= IDX_W'(BANK_SLOTS));
                if (exec) begin
                    n_bank_valid = 1'b1;
                end
            end
            MODE_READ: begin
                if (r_bank_valid && any_hit) begin
                    n_rt = sel_time;
                    n_rv = sel_value;
                end else begin
                    n_status = 1'b1;
                end
            end
            default: begin
                n_status = 1'b0;
            end
        endcase
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_stored_index = r_sidx;
    assign o_read_time    = r_rt;
    assign o_read_value   = r_rv;

endmodule

// ----- rtl/rssb_checker.sv -----
// Port-level checker for the retained sample slot bank.
// Depends on rssb_pkg for widths; bound to retained_sample_slot_bank_top below.
module rssb_checker
    import rssb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input logic              o_status,
    input logic [IDX_W-1:0]  o_stored_index,
    input logic [WORD_W-1:0] o_read_time,
    input logic [WORD_W-1:0] o_read_value
);

    // A transfer makes the block busy for the execute cycle.
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a transfer");

    // Every transfer yields its result after the execute cycle, from the result registers.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("result missing two cycles after a transfer");

    // Results cannot come in consecutive cycles.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe high in two consecutive cycles");

    // A nonzero stored index comes only from a successful store, with no read words.
    a_stored_index_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_stored_index != '0))
            |-> (!o_status && (o_read_time == '0) && (o_read_value == '0)))
        else $error("stored index reported alongside failure or read words");

    // A failed command never returns slot words.
    a_failure_no_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> ((o_read_time == '0) && (o_read_value == '0)))
        else $error("read words present on a failed command");

endmodule

bind retained_sample_slot_bank_top rssb_checker u_rssb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_status       (o_status),
    .o_stored_index (o_stored_index),
    .o_read_time    (o_read_time),
    .o_read_value   (o_read_value)
);

// ----- test/retained_sample_slot_bank_top_tb.sv -----
// Self-checking testbench for retained_sample_slot_bank_top.
// Depends on rssb_pkg and the bank RTL; a behavioural copy of the slot bank
// predicts every result, and a monitor compares each strobed result in order.
`timescale 1ns / 100ps

module retained_sample_slot_bank_top_tb
    import rssb_pkg::*;
();

    localparam int BANK_SLOTS   = 16;
    localparam int RANDOM_ITEMS = 1500;

    // One result as the bank reports it.
    typedef struct packed {
        logic              status;
        logic [IDX_W-1:0]  stored_index;
        logic [WORD_W-1:0] read_time;
        logic [WORD_W-1:0] read_value;
    } t_bank_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_mode;
    logic [IDX_W-1:0]  i_slot_index;
    logic [WORD_W-1:0] i_sample_time;
    logic [WORD_W-1:0] i_sample_value;
    logic              o_valid;
    logic              o_status;
    logic [IDX_W-1:0]  o_stored_index;
    logic [WORD_W-1:0] o_read_time;
    logic [WORD_W-1:0] o_read_value;

    retained_sample_slot_bank_top #(
        .BANK_SLOTS(BANK_SLOTS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_slot_index   (i_slot_index),
        .i_sample_time  (i_sample_time),
        .i_sample_value (i_sample_value),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_stored_index (o_stored_index),
        .o_read_time    (o_read_time),
        .o_read_value   (o_read_value)
    );

    // Shadow copy of the bank. Slot words are held at zero from the start,
    // which is harmless: the bank is wiped before it first becomes valid.
    logic              bank_open;
    logic [WORD_W-1:0] shadow_time  [BANK_SLOTS];
    logic [WORD_W-1:0] shadow_value [BANK_SLOTS];
    logic              shadow_used  [BANK_SLOTS];

    // Results predicted for accepted commands, oldest first.
    t_bank_result awaited_results[$];

    // Bookkeeping for the sender's bursts and for the closing summary.
    int burst_left;
    int fail_count;
    int results_seen;
    int mode_count [4];
    int full_count;
    int miss_count;

    always #5 i_clk = ~i_clk;

    function automatic void wipe_shadow();
        for (int k = 0; k < BANK_SLOTS; k++) begin
            shadow_time[k]  = '0;
            shadow_value[k] = '0;
            shadow_used[k]  = 1'b0;
        end
    endfunction

    // The first store of either kind wipes the bank and makes it valid.
    function automatic void open_bank();
        if (!bank_open) begin
            wipe_shadow();
            bank_open = 1'b1;
        end
    endfunction

    function automatic void write_slot(int k, logic [WORD_W-1:0] tw, logic [WORD_W-1:0] vw);
        shadow_time[k]  = tw;
        shadow_value[k] = vw;
        shadow_used[k]  = (tw != '0) || (vw != '0);
    endfunction

    // Applies one command to the shadow bank and returns the result it must give.
    function automatic t_bank_result predict_bank_op(t_mode mode, logic [IDX_W-1:0] idx,
                                                     logic [WORD_W-1:0] tw,
                                                     logic [WORD_W-1:0] vw);
        t_bank_result r;
        logic         found;
        int           slot;
        r     = '0;
        found = 1'b0;
        slot  = int'(idx);
        case (mode)
            MODE_STORE_FREE: begin
                open_bank();
                r.status = 1'b1;
                for (int k = 0; k < BANK_SLOTS; k++) begin
                    if (!found && !shadow_used[k]) begin
                        write_slot(k, tw, vw);
                        r.status       = 1'b0;
                        r.stored_index = IDX_W'(k);
                        found          = 1'b1;
                    end
                end
            end
            MODE_STORE_AT: begin
                open_bank();
                if (slot < BANK_SLOTS) begin
                    write_slot(slot, tw, vw);
                end else begin
                    r.status = 1'b1;
                end
            end
            MODE_READ: begin
                if (bank_open && slot < BANK_SLOTS && shadow_used[slot]) begin
                    r.read_time  = shadow_time[slot];
                    r.read_value = shadow_value[slot];
                end else begin
                    r.status = 1'b1;
                end
            end
            default: begin
                wipe_shadow();
            end
        endcase
        return r;
    endfunction

    // Sends one command. The sender works in bursts: before a new burst it may
    // drop start for a few cycles, so gaps land on every phase of the command
    // rhythm. A gap of zero gives long stretches of back-to-back work.
    task automatic send_op(input t_mode mode, input logic [IDX_W-1:0] idx,
                           input logic [WORD_W-1:0] tw, input logic [WORD_W-1:0] vw);
        int           gap;
        t_bank_result predicted;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            repeat (gap) begin
                @(negedge i_clk);
                start = 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        start          = 1'b1;
        i_mode         = mode;
        i_slot_index   = idx;
        i_sample_time  = tw;
        i_sample_value = vw;
        // The transfer happens at the first rising edge with busy low.
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        predicted = predict_bank_op(mode, idx, tw, vw);
        awaited_results.push_back(predicted);
        mode_count[mode]++;
        if (mode == MODE_STORE_FREE && predicted.status) full_count++;
        if (mode == MODE_READ && predicted.status) miss_count++;
    endtask

    // Result monitor: every strobed result is matched against the oldest
    // prediction. Values are those from before the edge, as the RTL updates
    // its registers with nonblocking assignments.
    always @(posedge i_clk) begin
        t_bank_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                $error("result strobed with no command outstanding");
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_stored_index !== want.stored_index) begin
                    $error("stored_index: expected %0d, got %0d",
                           want.stored_index, o_stored_index);
                    fail_count++;
                end
                if (o_read_time !== want.read_time) begin
                    $error("read_time: expected %h, got %h", want.read_time, o_read_time);
                    fail_count++;
                end
                if (o_read_value !== want.read_value) begin
                    $error("read_value: expected %h, got %h",
                           want.read_value, o_read_value);
                    fail_count++;
                end
            end
        end
    end

    // Before any store the bank is invalid: reads must miss, and a clear is
    // accepted without opening the bank. A store-at with an index out of range
    // fails but still opens (and wipes) the bank.
    task automatic test_invalid_bank();
        send_op(MODE_READ, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(MODE_READ, 6'd0, '0, '0);
        send_op(MODE_CLEAR, 6'd0, '0, '0);
        send_op(MODE_STORE_AT, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(MODE_READ, 6'd0, '0, '0);
    endtask

    // Fills every slot through store-first-free, then shows the bank full.
    task automatic test_fill_to_full();
        logic [WORD_W-1:0] tw;
        logic [WORD_W-1:0] vw;
        for (int k = 0; k < BANK_SLOTS; k++) begin
            case (k)
                0:       begin tw = 32'hFFFF_FFFF; vw = '0;           end
                1:       begin tw = '0;            vw = 32'hFFFF_FFFF; end
                2:       begin tw = '0;            vw = 32'h0000_0001; end
                default: begin tw = 32'h1 << (2 * k); vw = 32'h8000_0000 >> k; end
            endcase
            send_op(MODE_STORE_FREE, IDX_W'(k), tw, vw);
        end
        send_op(MODE_STORE_FREE, 6'd0, 32'h1234_5678, 32'h9ABC_DEF0);
        send_op(MODE_READ, IDX_W'(BANK_SLOTS - 1), '0, '0);
        send_op(MODE_READ, IDX_W'(BANK_SLOTS), '0, '0);
    endtask

    // Storing zero words into a slot leaves it empty, so a read misses and the
    // next store-first-free reuses that slot.
    task automatic test_store_at_empty();
        send_op(MODE_STORE_AT, 6'd5, '0, '0);
        send_op(MODE_READ, 6'd5, '0, '0);
        send_op(MODE_STORE_FREE, 6'd0, 32'hDEAD_BEEF, 32'h0BAD_F00D);
        send_op(MODE_READ, 6'd5, '0, '0);
    endtask

    // Clear empties every slot but keeps the bank valid.
    task automatic test_clear();
        send_op(MODE_CLEAR, 6'd0, '0, '0);
        send_op(MODE_READ, 6'd0, '0, '0);
        send_op(MODE_STORE_FREE, 6'd0, 32'h0000_0001, 32'h0000_0000);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Random traffic in phases. Each phase picks how often the bank is
    // cleared, so some phases fill the bank to full and keep it there while
    // others churn. Reads mostly target occupied slots so that stored words
    // are checked; the rest aim at random slots, in range or out of range.
    task automatic test_random();
        int                clear_pct;
        int                phase_left;
        int                roll;
        int                pick;
        t_mode             mode;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] tw;
        logic [WORD_W-1:0] vw;
        phase_left = 0;
        clear_pct  = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 80);
                case ($urandom_range(0, 2))
                    0:       clear_pct = 0;
                    1:       clear_pct = 2;
                    default: clear_pct = 10;
                endcase
            end
            phase_left--;
            roll = $urandom_range(0, 99);
            if (roll < clear_pct)      mode = MODE_CLEAR;
            else if (roll < 40)        mode = MODE_STORE_FREE;
            else if (roll < 60)        mode = MODE_STORE_AT;
            else                       mode = MODE_READ;
            idx = ($urandom_range(0, 99) < 85) ? IDX_W'($urandom_range(0, BANK_SLOTS - 1))
                                               : IDX_W'($urandom_range(BANK_SLOTS, 63));
            if (mode == MODE_READ && $urandom_range(0, 9) < 7) begin
                pick = $urandom_range(0, BANK_SLOTS - 1);
                for (int k = 0; k < BANK_SLOTS; k++) begin
                    if (shadow_used[(pick + k) % BANK_SLOTS]) begin
                        idx  = IDX_W'((pick + k) % BANK_SLOTS);
                        break;
                    end
                end
            end
            tw = pick_word();
            vw = pick_word();
            if (mode == MODE_STORE_AT && $urandom_range(0, 99) < 15) begin
                tw = '0;
                vw = '0;
            end
            send_op(mode, idx, tw, vw);
        end
    endtask

    // Overall time limit, far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("retained_sample_slot_bank_top_tb NOT OK");
        $finish;
    end

    initial begin
        i_clk          = 1'b0;
        start          = 1'b0;
        i_rst_n        = 1'b0;
        i_mode         = MODE_STORE_FREE;
        i_slot_index   = '0;
        i_sample_time  = '0;
        i_sample_value = '0;
        bank_open      = 1'b0;
        burst_left     = 0;
        fail_count     = 0;
        results_seen   = 0;
        full_count     = 0;
        miss_count     = 0;
        for (int m = 0; m < 4; m++) mode_count[m] = 0;
        wipe_shadow();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_invalid_bank();
        test_fill_to_full();
        test_store_at_empty();
        test_clear();
        test_random();

        // Drop start so the last command is not transferred a second time,
        // then let the outstanding results drain.
        @(negedge i_clk);
        start = 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Covered %0d store-free (%0d found the bank full), %0d store-at, %0d read",
                 mode_count[MODE_STORE_FREE], full_count, mode_count[MODE_STORE_AT],
                 mode_count[MODE_READ]);
        $display("(%0d missed) and %0d clear commands; %0d results checked, %0d mismatches.",
                 miss_count, mode_count[MODE_CLEAR], results_seen, fail_count);
        if (fail_count == 0) begin
            $display("retained_sample_slot_bank_top_tb OK");
        end else begin
            $display("retained_sample_slot_bank_top_tb NOT OK");
        end
        $finish;
    end

endmodule
